[hw/rtl/xbr_pkg.sv]
package xbr_pkg;

    // Link control characters
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_C   = 8'h43;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Block layout, counted from the byte after the first byte
    localparam int unsigned PAYLOAD_LEN = 128;
    localparam logic [7:0]  POS_PAYLOAD = 8'd2;
    localparam logic [7:0]  POS_TRAILER = POS_PAYLOAD + 8'(PAYLOAD_LEN);

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic KIND_REPLY   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic       transfer_done;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_BLOCK,
        PH_DONE
    } t_phase;

    // Work handed from the front end to the back end
    typedef enum logic [2:0] {
        OP_START_CRC,   // send 'C', clear accumulators
        OP_START_SUM,   // send NAK, clear accumulators
        OP_OPEN,        // first byte of a block, clear accumulators
        OP_EOT,         // ACK with transfer done
        OP_PAYLOAD,     // accumulate and forward
        OP_TRAIL_HI,    // latch CRC high byte
        OP_CHK_SUM,     // checksum byte versus running sum
        OP_CHK_LATE     // last trailer byte: CRC or latched byte versus sum
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       crc_mode;
        logic [7:0] data;
    } t_qentry;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/xbr_front.sv]
module xbr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  xbr_pkg::t_in_item i_in_item,
    input  logic             i_use_crc,
    input  logic             i_q_full,
    output logic             o_in_ready,
    output logic             o_push,
    output xbr_pkg::t_qentry o_entry
);
    import xbr_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_pos, n_pos;
    logic       accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        if (accept) begin
            if (!i_in_item.cmd) begin
                n_phase = PH_WAIT;
                n_pos   = '0;
            end else begin
                case (r_phase)
                    PH_WAIT: begin
                        n_phase = (i_in_item.rx_byte == CH_EOT) ? PH_DONE : PH_BLOCK;
                        n_pos   = '0;
                    end
                    PH_BLOCK: begin
                        if (r_pos < POS_TRAILER || (r_pos == POS_TRAILER && i_use_crc)) begin
                            n_pos = r_pos + 8'd1;
                        end else begin
                            n_phase = PH_WAIT;
                            n_pos   = '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // classification
    always_comb begin
        o_push        = 1'b0;
        o_entry.op    = OP_OPEN;
        o_entry.crc_mode = i_use_crc;
        o_entry.data  = i_in_item.rx_byte;
        if (accept) begin
            if (!i_in_item.cmd) begin
                o_push     = 1'b1;
                o_entry.op = i_use_crc ? OP_START_CRC : OP_START_SUM;
            end else begin
                case (r_phase)
                    PH_WAIT: begin
                        o_push     = 1'b1;
                        o_entry.op = (i_in_item.rx_byte == CH_EOT) ? OP_EOT : OP_OPEN;
                    end
                    PH_BLOCK: begin
                        if (r_pos < POS_PAYLOAD) begin
                            o_push = 1'b0;  // block number bytes
                        end else if (r_pos < POS_TRAILER) begin
                            o_push     = 1'b1;
                            o_entry.op = OP_PAYLOAD;
                        end else if (r_pos == POS_TRAILER) begin
                            o_push     = 1'b1;
                            o_entry.op = i_use_crc ? OP_TRAIL_HI : OP_CHK_SUM;
                        end else begin
                            o_push     = 1'b1;
                            o_entry.op = OP_CHK_LATE;
                        end
                    end
                    default: o_push = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

endmodule

[hw/rtl/xbr_fifo.sv]
module xbr_fifo #(
    parameter int unsigned DEPTH = xbr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  xbr_pkg::t_qentry i_entry,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output xbr_pkg::t_qentry o_entry
);
    import xbr_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_qentry         r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_entry = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;
    assign do_push = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

[hw/rtl/xbr_back.sv]
module xbr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  xbr_pkg::t_qentry  i_entry,
    input  logic              i_out_ready,
    output logic              o_pop,
    output logic              o_out_valid,
    output xbr_pkg::t_out_item o_out_item
);
    import xbr_pkg::*;

    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_hi, n_hi;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic        emit;
    t_out_item   res;
    logic        ok;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_crc = r_crc;
        n_sum = r_sum;
        n_hi  = r_hi;
        emit  = 1'b0;
        ok    = 1'b0;
        res.out_kind      = KIND_REPLY;
        res.out_byte      = i_entry.data;
        res.transfer_done = 1'b0;
        case (i_entry.op)
            OP_START_CRC, OP_START_SUM, OP_OPEN: begin
                n_crc = '0;
                n_sum = '0;
                n_hi  = '0;
                emit  = (i_entry.op != OP_OPEN);
                res.out_byte = (i_entry.op == OP_START_CRC) ? CH_C : CH_NAK;
            end
            OP_EOT: begin
                emit = 1'b1;
                res.out_byte      = CH_ACK;
                res.transfer_done = 1'b1;
            end
            OP_PAYLOAD: begin
                n_crc = crc16_byte(r_crc, i_entry.data);
                n_sum = r_sum + i_entry.data;
                emit  = 1'b1;
                res.out_kind = KIND_PAYLOAD;
            end
            OP_TRAIL_HI: n_hi = i_entry.data;
            OP_CHK_SUM: begin
                emit = 1'b1;
                ok   = (i_entry.data == r_sum);
                res.out_byte = ok ? CH_ACK : CH_NAK;
            end
            OP_CHK_LATE: begin
                emit = 1'b1;
                ok   = i_entry.crc_mode ? ({r_hi, i_entry.data} == r_crc) : (r_hi == r_sum);
                res.out_byte = ok ? CH_ACK : CH_NAK;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= '0;
            r_sum       <= '0;
            r_hi        <= '0;
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_crc       <= n_crc;
            r_sum       <= n_sum;
            r_hi        <= n_hi;
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_item <= res;
        end
    end

endmodule

[hw/rtl/xmodem_block_receiver.sv]
// XMODEM block receiver, one link byte (or a start command) per input item.
// Throughput is one item per clock while o_in_ready is high: the front end
// tracks the block framing and classifies each item in the cycle it is accepted,
// the back end keeps the CRC-16 / 8-bit sum and drives a registered result.
// A small queue (QUEUE_DEPTH entries, default 2) sits between them; o_in_ready
// drops only when that queue is full, which at a depth of 2 or more happens
// only while the result consumer holds i_out_ready low. The first byte of a
// block, its block number bytes and the CRC high byte produce no result. The
// use_crc register (reset 1) is written through i_cfg_we / i_cfg_wdata and
// should be changed only with no item in flight.
module xmodem_block_receiver #(
    parameter int unsigned QUEUE_DEPTH = xbr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  xbr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output xbr_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);
    import xbr_pkg::*;

    logic    r_use_crc;
    logic    push, q_full, q_valid, pop;
    t_qentry front_entry, q_entry;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_crc <= 1'b1;
        end else if (i_cfg_we) begin
            r_use_crc <= i_cfg_wdata;
        end
    end

    // Framing and classification
    xbr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_use_crc  (r_use_crc),
        .i_q_full   (q_full),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_entry    (front_entry)
    );

    // Decoupling queue
    xbr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_entry (q_entry)
    );

    // Check accumulation and result register
    xbr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_entry     (q_entry),
        .i_out_ready (i_out_ready),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

`ifndef ASSERT_OFF
    // A start command always leaves work queued for the back end
    a_start_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_item.cmd |=> q_valid)
        else $error("start item not queued");

    // Transfer done only ever rides on an ACK reply
    a_done_is_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.transfer_done |->
            o_out_item.out_kind == KIND_REPLY && o_out_item.out_byte == CH_ACK)
        else $error("transfer_done on non-ACK item");

    // Back end must not consume while a result is stalled
    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !pop)
        else $error("queue popped under output stall");
`endif

endmodule
